[sv/substring_first_match_search_defines.svh]
// assertion macros shared by the checker of substring_first_match_search
// no dependencies
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ssfm_pkg.sv]
// types, register indexes and helpers for substring_first_match_search
// no dependencies
package ssfm_pkg;

    localparam int NEEDLE_BYTES = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int LEN_W        = 5;
    localparam int POS_W        = 32;

    typedef enum logic [1:0] {
        REG_NEEDLE_LOW  = 2'd0,
        REG_NEEDLE_HIGH = 2'd1,
        REG_NEEDLE_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [LEN_W-1:0]      len;
    } needle_t;

    function automatic logic [7:0] needle_byte(needle_t needle, logic [3:0] idx);
        logic [5:0] bit_pos;
        bit_pos = {idx[2:0], 3'b000};
        if (idx[3])
        begin
            return needle.high[bit_pos +: 8];
        end
        return needle.low[bit_pos +: 8];
    endfunction

endpackage

[sv/ssfm_in_if.sv]
// text item channel: one text byte or an end-of-text mark
// no dependencies
interface ssfm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[sv/ssfm_out_if.sv]
// result item channel: found flag and start offset
// no dependencies
interface ssfm_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink (input valid, input found, input match_position, output ready);
endinterface

[sv/ssfm_compare.sv]
// masked window compare against the needle, reversed byte order
// depends on ssfm_pkg
module ssfm_compare
    import ssfm_pkg::*;
#(
    parameter int MAX_NEEDLE = 16
)
(
    input  logic [7:0]       window [MAX_NEEDLE],
    input  needle_t          needle,
    input  logic [LEN_W-1:0] len,
    output logic             match
);

    always_comb
    begin
        logic [LEN_W-1:0] idx;
        match = 1'b1;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            idx = len - LEN_W'(k) - LEN_W'(1);
            if (LEN_W'(k) < len && window[k] != needle_byte(needle, idx[3:0]))
            begin
                match = 1'b0;
            end
        end
    end

endmodule

[sv/substring_first_match_search.sv]
// first-match substring search over a byte stream
// an accepted item is registered in the input stage, then in the result register
// throughput: one item per cycle; the input stage stalls only while a result waits
// rst_n clears window, byte count, match flag, needle registers and both stages
// depends on ssfm_pkg, ssfm_in_if, ssfm_out_if, ssfm_compare
module substring_first_match_search
    import ssfm_pkg::*;
#(
    parameter int MAX_NEEDLE = 16,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ssfm_in_if.sink               text_in,
    ssfm_out_if.source            result_out
);

    localparam int WIDE_W = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;

    needle_t               needle_reg;
    logic                  stage_valid_reg;
    logic [7:0]            stage_byte_reg;
    logic                  stage_eot_reg;
    logic [7:0]            window_reg [MAX_NEEDLE];
    logic [7:0]            window_next [MAX_NEEDLE];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  reported_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [POS_W-1:0]      out_pos_reg;

    logic                  advance;
    logic [LEN_W-1:0]      len_eff;
    logic                  match;
    logic                  emit;
    logic                  emit_found;
    logic [POS_W-1:0]      emit_pos;
    logic                  do_clear;
    logic                  do_shift;
    logic                  set_reported;
    logic [COUNT_BITS-1:0] offset;
    logic [WIDE_W-1:0]     offset_wide;

    assign advance       = stage_valid_reg && (!out_valid_reg || result_out.ready);
    assign text_in.ready = !stage_valid_reg || advance;

    assign len_eff = (needle_reg.len > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : needle_reg.len;

    always_comb
    begin
        window_next[0] = stage_byte_reg;
        for (int k = 1; k < MAX_NEEDLE; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    assign count_next  = (&count_reg) ? count_reg : count_reg + COUNT_BITS'(1);
    assign offset      = count_next - COUNT_BITS'(len_eff);
    assign offset_wide = WIDE_W'(offset);

    ssfm_compare #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_compare (
        .window (window_next),
        .needle (needle_reg),
        .len    (len_eff),
        .match  (match)
    );

    always_comb
    begin
        emit         = 1'b0;
        emit_found   = 1'b0;
        emit_pos     = '0;
        do_clear     = 1'b0;
        do_shift     = 1'b0;
        set_reported = 1'b0;
        priority if (!reported_reg && len_eff == '0)
        begin
            emit       = 1'b1;
            emit_found = 1'b1;
            if (stage_eot_reg)
            begin
                do_clear = 1'b1;
            end
            else
            begin
                set_reported = 1'b1;
            end
        end
        else if (stage_eot_reg)
        begin
            do_clear = 1'b1;
            emit     = !reported_reg;
        end
        else if (!reported_reg)
        begin
            do_shift = 1'b1;
            if (count_next >= COUNT_BITS'(len_eff) && match)
            begin
                emit         = 1'b1;
                emit_found   = 1'b1;
                emit_pos     = offset_wide[POS_W-1:0];
                set_reported = 1'b1;
            end
        end
        else
        begin
            // bytes after the match are ignored
            do_shift = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEEDLE_LOW:  needle_reg.low  <= cfg_data;
                REG_NEEDLE_HIGH: needle_reg.high <= cfg_data;
                REG_NEEDLE_LEN:  needle_reg.len  <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            stage_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            stage_byte_reg <= text_in.text_byte;
            stage_eot_reg  <= text_in.end_of_text;
        end
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_NEEDLE; k++)
            begin
                window_reg[k] <= '0;
            end
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (do_clear)
            begin
                for (int k = 0; k < MAX_NEEDLE; k++)
                begin
                    window_reg[k] <= '0;
                end
                count_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                if (do_shift)
                begin
                    window_reg <= window_next;
                    count_reg  <= count_next;
                end
                if (set_reported)
                begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_found_reg <= emit_found;
            out_pos_reg   <= emit_pos;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.found          = out_found_reg;
    assign result_out.match_position = out_pos_reg;

endmodule

[sv/ssfm_checker.sv]
// port-level checks for substring_first_match_search, bound to the top level
// depends on substring_first_match_search_defines.svh
`include "substring_first_match_search_defines.svh"

module ssfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_found,
    input logic [31:0] out_pos
);

    `SSFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_pos), "result changed while stalled")
    `SSFM_ASSERT_IMPLY(a_not_found_pos, clk, rst_n, out_valid && !out_found, out_pos == 32'd0, "position nonzero without a match")
    `SSFM_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")
    `SSFM_ASSERT_NEXT(a_stall_fill, clk, rst_n, !in_ready, in_ready == out_ready, "stall release off the result side")

endmodule

bind substring_first_match_search ssfm_checker u_ssfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_found (result_out.found),
    .out_pos   (result_out.match_position)
);
